// File: hw/rtl/hsl_fade_to_rgb_defines.svh
// Assertion macros used by the checker file of hsl_fade_to_rgb.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef HSL_FADE_TO_RGB_DEFINES_SVH
`define HSL_FADE_TO_RGB_DEFINES_SVH

// Implication checked at every edge outside reset.
`define HFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsl_fade_to_rgb: implication failed");

// Condition that must never be seen outside reset.
`define HFR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hsl_fade_to_rgb: forbidden condition seen");

`endif

// File: hw/rtl/hfr_pkg.sv
// Shared constants and types of the HSL fade to RGB888 block.
// No dependencies; used by the top level and its checker.
package hfr_pkg;

  localparam int HUE_W   = 13;
  localparam int CH_W    = 8;
  localparam int STEPS_W = 16;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // product diff*pos and the restoring divider over it
  localparam int PROD_W    = HUE_W + STEPS_W;
  localparam int DIV_STEPS = HUE_W;
  localparam int NLANE     = 3;

  localparam int HUE_SIXTY = 960;
  localparam int FULL      = 255;
  localparam int MDEN      = 489600;        // 65025*960*2/255
  localparam int NUM_W     = 28;
  localparam int NSH       = 7;             // MDEN = 128 * 3825
  localparam int RDIV      = 3825;
  localparam int NSH_W     = NUM_W - NSH;
  localparam int RECIP     = 1122867;       // floor(2^32 / 3825)
  localparam int RECIP_W   = 21;
  localparam int RPROD_W   = NSH_W + RECIP_W;
  localparam int Q_W       = RPROD_W - 32;

  // pipeline depth from the accepting edge to the edge that takes the result
  localparam int LATENCY = 22;

  typedef enum logic [2:0] {
    REG_START_HUE = 3'd0,
    REG_START_SAT = 3'd1,
    REG_START_LIT = 3'd2,
    REG_END_HUE   = 3'd3,
    REG_END_SAT   = 3'd4,
    REG_END_LIT   = 3'd5,
    REG_STEPS     = 3'd6
  } reg_idx_t;

endpackage

// File: hw/rtl/hsl_fade_to_rgb.sv
// Top level: HSL fade interpolation and HSL to RGB888 conversion pipeline.
// Depends on hfr_pkg.
// Throughput: one item per cycle; a 13-stage restoring divider (one quotient
// bit per stage, three lanes) sets the depth; busy is raised only in reset.
// Reset: synchronous, active low; clears all valid bits and the configuration registers
// (steps to one). The receiver cannot stall the pipeline.
module hsl_fade_to_rgb (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [hfr_pkg::STEPS_W-1:0]  in_fade_position,
  output logic                         out_valid,
  output logic [hfr_pkg::CH_W-1:0]     out_red,
  output logic [hfr_pkg::CH_W-1:0]     out_green,
  output logic [hfr_pkg::CH_W-1:0]     out_blue,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [hfr_pkg::PDATA_W-1:0]  pwdata,
  output logic [hfr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import hfr_pkg::*;

  // configuration registers
  logic [HUE_W-1:0]   s_hue_r, e_hue_r;
  logic [CH_W-1:0]    s_sat_r, s_lit_r, e_sat_r, e_lit_r;
  logic [STEPS_W-1:0] steps_r;
  reg_idx_t           ridx;

  assign ridx   = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;
  // hold off transfers while reset is applied
  assign busy   = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_hue_r <= '0; s_sat_r <= '0; s_lit_r <= '0;
      e_hue_r <= '0; e_sat_r <= '0; e_lit_r <= '0;
      steps_r <= STEPS_W'(1);
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_START_HUE: s_hue_r <= pwdata[HUE_W-1:0];
        REG_START_SAT: s_sat_r <= pwdata[CH_W-1:0];
        REG_START_LIT: s_lit_r <= pwdata[CH_W-1:0];
        REG_END_HUE:   e_hue_r <= pwdata[HUE_W-1:0];
        REG_END_SAT:   e_sat_r <= pwdata[CH_W-1:0];
        REG_END_LIT:   e_lit_r <= pwdata[CH_W-1:0];
        REG_STEPS:     steps_r <= pwdata[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_START_HUE: prdata = PDATA_W'(s_hue_r);
      REG_START_SAT: prdata = PDATA_W'(s_sat_r);
      REG_START_LIT: prdata = PDATA_W'(s_lit_r);
      REG_END_HUE:   prdata = PDATA_W'(e_hue_r);
      REG_END_SAT:   prdata = PDATA_W'(e_sat_r);
      REG_END_LIT:   prdata = PDATA_W'(e_lit_r);
      REG_STEPS:     prdata = PDATA_W'(steps_r);
      default:       prdata = '0;
    endcase
  end

  // per-lane endpoints: hue, saturation, lightness (user keeps them stable while items run; not enforced here)
  logic [STEPS_W-1:0] steps_eff;
  logic [HUE_W-1:0]   from_v [NLANE];
  logic [HUE_W-1:0]   to_v   [NLANE];
  logic [HUE_W-1:0]   diff_v [NLANE];
  logic               up_v   [NLANE];

  always_comb begin
    steps_eff = (steps_r == '0) ? STEPS_W'(1) : steps_r;
    from_v[0] = s_hue_r;          to_v[0] = e_hue_r;
    from_v[1] = HUE_W'(s_sat_r);  to_v[1] = HUE_W'(e_sat_r);
    from_v[2] = HUE_W'(s_lit_r);  to_v[2] = HUE_W'(e_lit_r);
    for (int i = 0; i < NLANE; i++) begin
      up_v[i]   = to_v[i] >= from_v[i];
      diff_v[i] = up_v[i] ? to_v[i] - from_v[i] : from_v[i] - to_v[i];
    end
  end

  // valid bits travel alongside the data
  logic [LATENCY-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], start};
    end
  end

  // stage 0: clamp position
  logic [STEPS_W-1:0] pos_r;
  always_ff @(posedge clk) begin
    pos_r <= (in_fade_position > steps_eff) ? steps_eff : in_fade_position;
  end

  // stage 1: diff * pos
  logic [PROD_W-1:0] prod_r [NLANE];
  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      prod_r[i] <= PROD_W'(diff_v[i]) * PROD_W'(pos_r);
    end
  end

  // stages 2..14: restoring division by steps, one quotient bit per stage
  logic [PROD_W-1:0] rem_r   [DIV_STEPS][NLANE];
  logic [HUE_W-1:0]  quo_r   [DIV_STEPS][NLANE];
  logic [PROD_W-1:0] rem_nxt [DIV_STEPS][NLANE];
  logic [HUE_W-1:0]  quo_nxt [DIV_STEPS][NLANE];

  always_comb begin
    logic [PROD_W-1:0] src;
    logic [PROD_W-1:0] dsh;
    logic [HUE_W-1:0]  qs;
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < NLANE; i++) begin
        src = (k == 0) ? prod_r[i] : rem_r[(k == 0) ? 0 : k-1][i];
        qs  = (k == 0) ? '0 : quo_r[(k == 0) ? 0 : k-1][i];
        dsh = PROD_W'(steps_eff) << (DIV_STEPS - 1 - k);
        if (src >= dsh) begin
          rem_nxt[k][i] = src - dsh;
          qs[DIV_STEPS-1-k] = 1'b1;
        end else begin
          rem_nxt[k][i] = src;
        end
        quo_nxt[k][i] = qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // stage 15: blended hue, saturation, lightness
  logic [HUE_W-1:0] hue_r;
  logic [CH_W-1:0]  sat_r, lit_r;
  logic [HUE_W-1:0] bl [NLANE];

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      bl[i] = up_v[i] ? from_v[i] + quo_r[DIV_STEPS-1][i]
                      : from_v[i] - quo_r[DIV_STEPS-1][i];
    end
  end

  always_ff @(posedge clk) begin
    hue_r <= bl[0];
    sat_r <= bl[1][CH_W-1:0];
    lit_r <= bl[2][CH_W-1:0];
  end

  // stage 16: chroma, X factor, sector
  logic [2*CH_W-1:0] cn_r;
  logic [10:0]       xf_r;
  logic [2:0]        sec_r;
  logic [CH_W-1:0]   lit2_r;
  logic [8:0]        twol, dev;
  logic [3:0]        hk;
  logic [HUE_W-1:0]  hbase, tt, tdev;
  logic [2:0]        sec;

  always_comb begin
    twol = {lit_r, 1'b0};
    dev  = (twol >= 9'(FULL)) ? twol - 9'(FULL) : 9'(FULL) - twol;
    hk = '0;
    for (int j = 1; j <= 8; j++) begin
      if (hue_r >= HUE_W'(HUE_SIXTY * j)) hk = 4'(j);
    end
    case (hk[3:1])
      3'd0:    hbase = HUE_W'(0);
      3'd1:    hbase = HUE_W'(2 * HUE_SIXTY);
      3'd2:    hbase = HUE_W'(4 * HUE_SIXTY);
      3'd3:    hbase = HUE_W'(6 * HUE_SIXTY);
      default: hbase = HUE_W'(8 * HUE_SIXTY);
    endcase
    tt   = hue_r - hbase;
    tdev = (tt >= HUE_W'(HUE_SIXTY)) ? tt - HUE_W'(HUE_SIXTY) : HUE_W'(HUE_SIXTY) - tt;
    // wrap past 360 degrees
    sec = (hk >= 4'd6) ? 3'(hk - 4'd6) : hk[2:0];
  end

  always_ff @(posedge clk) begin
    cn_r   <= (2*CH_W)'(8'(9'(FULL) - dev)) * (2*CH_W)'(sat_r);
    xf_r   <= 11'(HUE_W'(HUE_SIXTY) - tdev);
    sec_r  <= sec;
    lit2_r <= lit_r;
  end

  // stage 17: channel terms in units of 1/(65025*960*2)
  logic [NUM_W-1:0] cv_r, xv_r, mn_r;
  logic [NUM_W-1:0] lm, c960;

  always_comb begin
    lm   = NUM_W'(lit2_r) * NUM_W'(MDEN);
    c960 = NUM_W'(cn_r) * NUM_W'(HUE_SIXTY);
  end

  logic [2:0] sec2_r;
  always_ff @(posedge clk) begin
    cv_r   <= NUM_W'(cn_r) * NUM_W'(2 * HUE_SIXTY);
    xv_r   <= (NUM_W'(cn_r) * NUM_W'(xf_r)) << 1;
    mn_r   <= (lm >= c960) ? lm - c960 : '0;
    sec2_r <= sec_r;
  end

  // stage 18: sector routing and numerator, pre-shifted by 128
  logic [NSH_W-1:0] nsh_r [NLANE];
  logic [NUM_W-1:0] vsel  [NLANE];
  logic [NUM_W-1:0] nsum  [NLANE];

  always_comb begin
    case (sec2_r)
      3'd0:    begin vsel[0] = cv_r; vsel[1] = xv_r; vsel[2] = '0;   end
      3'd1:    begin vsel[0] = xv_r; vsel[1] = cv_r; vsel[2] = '0;   end
      3'd2:    begin vsel[0] = '0;   vsel[1] = cv_r; vsel[2] = xv_r; end
      3'd3:    begin vsel[0] = '0;   vsel[1] = xv_r; vsel[2] = cv_r; end
      3'd4:    begin vsel[0] = xv_r; vsel[1] = '0;   vsel[2] = cv_r; end
      default: begin vsel[0] = cv_r; vsel[1] = '0;   vsel[2] = xv_r; end
    endcase
    for (int i = 0; i < NLANE; i++) begin
      nsum[i] = vsel[i] + mn_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      nsh_r[i] <= nsum[i][NUM_W-1:NSH];
    end
  end

  // stage 19: reciprocal product for the divide by 3825
  logic [RPROD_W-1:0] rp_r  [NLANE];
  logic [NSH_W-1:0]   nsh2_r [NLANE];
  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      rp_r[i]   <= RPROD_W'(nsh_r[i]) * RPROD_W'(RECIP);
      nsh2_r[i] <= nsh_r[i];
    end
  end

  // stage 20: estimate and remainder; estimate is exact or one short
  logic [Q_W-1:0]   qe_r [NLANE];
  logic [NSH_W-1:0] rm_r [NLANE];
  logic [Q_W-1:0]   qe   [NLANE];

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      qe[i] = rp_r[i][RPROD_W-1:32];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      qe_r[i] <= qe[i];
      rm_r[i] <= nsh2_r[i] - NSH_W'(NSH_W'(qe[i]) * NSH_W'(RDIV));
    end
  end

  // stage 21: correct, clamp, present
  logic [Q_W-1:0]  qc  [NLANE];
  logic [CH_W-1:0] chv [NLANE];

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      qc[i]  = qe_r[i] + ((rm_r[i] >= NSH_W'(RDIV)) ? Q_W'(1) : Q_W'(0));
      chv[i] = (qc[i] > Q_W'(FULL)) ? CH_W'(FULL) : qc[i][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= chv[0];
    out_green <= chv[1];
    out_blue  <= chv[2];
  end

  assign out_valid = vld_r[LATENCY-1];

endmodule

// File: hw/rtl/hfr_checker.sv
// Port-level checker for hsl_fade_to_rgb, bound to the top level.
// Depends on hfr_pkg and hsl_fade_to_rgb_defines.svh.
`include "hsl_fade_to_rgb_defines.svh"

module hfr_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import hfr_pkg::*;

  // cycles since reset, saturating at the pipeline depth
  logic [5:0] seen_r;
  logic       warm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (seen_r != 6'(LATENCY)) begin
      seen_r <= seen_r + 6'd1;
    end
  end

  assign warm = (seen_r == 6'(LATENCY));

  `HFR_ASSERT_NEVER(a_never_busy, busy)
  `HFR_ASSERT_IMP(a_result_per_transfer, warm, out_valid == $past(start, LATENCY))
  `HFR_ASSERT_IMP(a_quiet_after_reset, !warm, !out_valid || (seen_r == 6'(LATENCY)))

endmodule

bind hsl_fade_to_rgb hfr_checker u_hfr_checker (.*);

// File: bench/hsl_fade_to_rgb_test.sv
// Self-checking testbench for hsl_fade_to_rgb: fade positions in, RGB888 colours out.
// Depends on hfr_pkg and the hsl_fade_to_rgb top level; predicts each colour itself.
`timescale 1ns / 100ps

module hsl_fade_to_rgb_test;
  import hfr_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [STEPS_W-1:0]   in_fade_position = '0;
  logic                 out_valid;
  logic [CH_W-1:0]      out_red, out_green, out_blue;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } colour_t;

  localparam int WATCHDOG_LIMIT = 2000;

  colour_t     pending_colours[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          timed_out = 1'b0;
  bit          burst_mode = 1'b0;

  // local copy of the colour registers
  logic [HUE_W-1:0]   hue_from, hue_to;
  logic [CH_W-1:0]    sat_from, sat_to, lit_from, lit_to;
  logic [STEPS_W-1:0] steps_reg;

  hsl_fade_to_rgb u_top (
    .clk, .rst_n, .start, .busy, .in_fade_position,
    .out_valid, .out_red, .out_green, .out_blue,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned lerp(longint unsigned from, longint unsigned to,
                                           longint unsigned pos, longint unsigned steps);
    if (to >= from) return from + ((to - from) * pos) / steps;
    return from - ((from - to) * pos) / steps;
  endfunction

  function automatic logic [CH_W-1:0] to_channel(longint unsigned num);
    longint unsigned q;
    q = num / 489600;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic colour_t fade_colour(logic [STEPS_W-1:0] position);
    longint unsigned steps, pos, h, s, l, dev, chroma, t, tdev, cv, xv, mnum;
    longint unsigned r, g, b;
    int unsigned     sector;
    colour_t         c;
    steps = (steps_reg == 0) ? 1 : steps_reg;
    pos = (position > steps) ? steps : position;
    h = lerp(hue_from, hue_to, pos, steps);
    s = lerp(sat_from, sat_to, pos, steps);
    l = lerp(lit_from, lit_to, pos, steps);
    dev = (2 * l >= 255) ? 2 * l - 255 : 255 - 2 * l;
    if (dev > 255) dev = 255;
    chroma = (255 - dev) * s;
    t = h % 1920;
    tdev = (t >= 960) ? t - 960 : 960 - t;
    cv = chroma * 1920;
    xv = chroma * (960 - tdev) * 2;
    mnum = l * 489600;
    mnum = (mnum >= chroma * 960) ? mnum - chroma * 960 : 0;
    sector = 32'((h / 960) % 6);
    case (sector)
      0: begin r = cv; g = xv; b = 0; end
      1: begin r = xv; g = cv; b = 0; end
      2: begin r = 0; g = cv; b = xv; end
      3: begin r = 0; g = xv; b = cv; end
      4: begin r = xv; g = 0; b = cv; end
      default: begin r = cv; g = 0; b = xv; end
    endcase
    c.red = to_channel(r + mnum);
    c.green = to_channel(g + mnum);
    c.blue = to_channel(b + mnum);
    return c;
  endfunction

  // check every colour against the oldest prediction
  always @(posedge clk) begin
    colour_t want;
    if (rst_n && out_valid) begin
      if (pending_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected colour %0d/%0d/%0d", out_red, out_green, out_blue);
      end else begin
        want = pending_colours.pop_front();
        if (want.red !== out_red || want.green !== out_green || want.blue !== out_blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("colour mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                     want.red, want.green, want.blue, out_red, out_green, out_blue);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("hsl_fade_to_rgb regression: fail");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_W'(4 * idx); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_START_HUE: hue_from = value[HUE_W-1:0];
      REG_START_SAT: sat_from = value[7:0];
      REG_START_LIT: lit_from = value[7:0];
      REG_END_HUE:   hue_to = value[HUE_W-1:0];
      REG_END_SAT:   sat_to = value[7:0];
      REG_END_LIT:   lit_to = value[7:0];
      default:       steps_reg = value[STEPS_W-1:0];
    endcase
  endtask

  task automatic set_fade(int unsigned h0, int unsigned s0, int unsigned l0,
                          int unsigned h1, int unsigned s1, int unsigned l1,
                          int unsigned steps);
    wait (pending_colours.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    write_reg(REG_START_HUE, h0);
    write_reg(REG_START_SAT, s0);
    write_reg(REG_START_LIT, l0);
    write_reg(REG_END_HUE, h1);
    write_reg(REG_END_SAT, s1);
    write_reg(REG_END_LIT, l1);
    write_reg(REG_STEPS, steps);
  endtask

  // send one position; start stays high through a burst, drops in a gap
  task automatic send_position(logic [STEPS_W-1:0] position);
    if (!burst_mode || $urandom_range(0, 7) == 0) begin
      burst_mode = $urandom_range(0, 3) != 0;
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start <= 1'b1;
    in_fade_position <= position;
    do @(posedge clk); while (busy);
    pending_colours.push_back(fade_colour(position));
  endtask

  task automatic release_start;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic test_extremes;
    set_fade(0, 255, 128, 5759, 0, 255, 16);
    for (int p = 0; p <= 17; p++) send_position(STEPS_W'(p));
    send_position(16'hFFFF);
    release_start();
    // single step, zero step count, hue beyond one turn
    set_fade(8191, 0, 0, 8191, 255, 255, 0);
    send_position(16'd0); send_position(16'd1); send_position(16'hFFFF);
    release_start();
    set_fade(5759, 255, 255, 0, 255, 0, 65535);
    send_position(16'd0); send_position(16'd32768); send_position(16'd65535);
    release_start();
  endtask

  task automatic test_random_fades;
    int unsigned steps;
    for (int phase = 0; phase < 12; phase++) begin
      steps = (phase % 4 == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 40);
      set_fade($urandom_range(0, 8191), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 8191), $urandom_range(0, 255), $urandom_range(0, 255),
               steps);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 3) == 0) send_position(STEPS_W'($urandom_range(0, 65535)));
        else send_position(STEPS_W'($urandom_range(0, steps + 2)));
      end
      release_start();
    end
  endtask

  initial begin
    hue_from = '0; hue_to = '0; sat_from = '0; sat_to = '0;
    lit_from = '0; lit_to = '0; steps_reg = 16'd1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_random_fades();
    wait (pending_colours.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && pending_colours.size() == 0)
      $display("hsl_fade_to_rgb regression: pass");
    else
      $display("hsl_fade_to_rgb regression: fail");
    $finish;
  end

endmodule
